// ===== hdl/plst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg
// Shared constants and types of the positional list engine.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                     valid;
    logic                     status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         length;
  } result_t;

endpackage

// ===== hdl/plst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module plst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/plst_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_seq
// Command sequencer: checks each command against the list length, moves
// entries through the RAM one per cycle, and presents the result.
// ----------------------------------------------------------------------------
module plst_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [plst_pkg::CMD_W-1:0]        cmd,
  input  logic [plst_pkg::POS_W-1:0]        position,
  input  logic signed [plst_pkg::DATA_W-1:0] value,
  output plst_pkg::mem_req_t                mem_req,
  input  logic [plst_pkg::DATA_W-1:0]       rdata,
  output plst_pkg::result_t                 res,
  input  logic                              slot_free
);
  import plst_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SHIFT  = 2'd1;
  localparam logic [1:0] ST_PUT    = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]        st, st_next;
  logic [CMD_W-1:0]  cmd_q, cmd_q_next;
  logic [ADDR_W-1:0] pidx, pidx_next;
  logic [DATA_W-1:0] val_q, val_q_next;
  logic              ok, ok_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              last, last_next;
  logic [CNT_W-1:0]  count, count_next;

  logic [POS_W:0]    pos8, cnt8;
  logic [ADDR_W-1:0] pos_m1, pos_idx, cnt_m1;
  logic              ins_ok, del_ok, get_ok, is_ins;

  assign pos8    = {1'b0, position};
  assign cnt8    = (POS_W + 1)'(count);
  assign pos_m1  = ADDR_W'(position - POS_W'(1));
  assign pos_idx = ADDR_W'(position);
  assign cnt_m1  = ADDR_W'(count - CNT_W'(1));
  assign ins_ok  = (position != '0) && (pos8 <= cnt8 + (POS_W + 1)'(1))
                   && (cnt8 < (POS_W + 1)'(CAPACITY));
  assign del_ok  = (position != '0) && (pos8 <= cnt8);
  assign get_ok  = del_ok;
  assign is_ins  = (cmd_q == CMD_INSERT);
  assign req_stall = (st != ST_IDLE);

  always_comb begin
    st_next    = st;
    cmd_q_next = cmd_q;
    pidx_next  = pidx;
    val_q_next = val_q;
    ok_next    = ok;
    ptr_next   = ptr;
    last_next  = last;
    count_next = count;
    mem_req    = '0;
    res        = '0;
    unique case (st)
      ST_IDLE: begin
        if (req_valid) begin
          cmd_q_next = cmd;
          pidx_next  = pos_m1;
          val_q_next = value;
          ok_next    = 1'b0;
          st_next    = ST_RESULT;
          if (cmd == CMD_INSERT && ins_ok) begin
            ok_next = 1'b1;
            if (pos8 <= cnt8) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = cnt_m1;
              ptr_next      = cnt_m1;
              last_next     = (pos8 == cnt8);
              st_next       = ST_SHIFT;
            end else begin
              st_next = ST_PUT;
            end
          end else if (cmd == CMD_DELETE && del_ok) begin
            ok_next = 1'b1;
            if (pos8 < cnt8) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = pos_idx;
              ptr_next      = pos_idx;
              last_next     = (pos8 + (POS_W + 1)'(1) == cnt8);
              st_next       = ST_SHIFT;
            end
          end else if (cmd == CMD_GET && get_ok) begin
            ok_next       = 1'b1;
            mem_req.re    = 1'b1;
            mem_req.raddr = pos_m1;
          end
        end
      end
      ST_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = is_ins ? ptr + ADDR_W'(1) : ptr - ADDR_W'(1);
        mem_req.wdata = rdata;
        if (!last) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = is_ins ? ptr - ADDR_W'(1) : ptr + ADDR_W'(1);
          ptr_next      = mem_req.raddr;
          last_next     = is_ins ? (mem_req.raddr == pidx) : (mem_req.raddr == cnt_m1);
        end else begin
          st_next = is_ins ? ST_PUT : ST_RESULT;
        end
      end
      ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pidx;
        mem_req.wdata = val_q;
        st_next       = ST_RESULT;
      end
      ST_RESULT: begin
        if (ok && cmd_q == CMD_INSERT) begin
          count_next = count + CNT_W'(1);
        end else if (ok && cmd_q == CMD_DELETE) begin
          count_next = count - CNT_W'(1);
        end
        res.valid      = 1'b1;
        res.status     = !ok;
        res.read_value = (ok && cmd_q == CMD_GET) ? rdata : '0;
        res.length     = POS_W'(count_next);
        if (slot_free) begin
          st_next = ST_IDLE;
        end else begin
          count_next = count;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      count <= '0;
    end else begin
      st    <= st_next;
      count <= count_next;
    end
    cmd_q <= cmd_q_next;
    pidx  <= pidx_next;
    val_q <= val_q_next;
    ok    <= ok_next;
    ptr   <= ptr_next;
    last  <= last_next;
  end

endmodule

// ===== hdl/positional_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed 32-bit values with insert, delete
// and get by 1-based position.
// ----------------------------------------------------------------------------
// The list is held in a single RAM with one write port and a registered
// read port, and the block works on one transaction at a time. A get or any
// rejected command goes from acceptance straight to the result. A delete or
// an insert at position p first shifts the tail of the list, since every
// moved entry needs one RAM read and one RAM write and the shift pipeline
// moves one entry per cycle; an insert then writes the new value. The result is
// held in an output register, so a new command is accepted while a result
// still waits to be taken.
module positional_list_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [plst_pkg::CMD_W-1:0]         cmd,
  input  logic [plst_pkg::POS_W-1:0]         position,
  input  logic signed [plst_pkg::DATA_W-1:0] value,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic                               status,
  output logic signed [plst_pkg::DATA_W-1:0] read_value,
  output logic [plst_pkg::POS_W-1:0]         length
);
  import plst_pkg::*;

  mem_req_t          mem_req;
  result_t           res;
  logic [DATA_W-1:0] rdata;
  logic              slot_free;

  assign slot_free = !rsp_valid || !rsp_stall;

  plst_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_W),
    .AW   (ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(rdata)
  );

  plst_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .cmd      (cmd),
    .position (position),
    .value    (value),
    .mem_req  (mem_req),
    .rdata    (rdata),
    .res      (res),
    .slot_free(slot_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (slot_free) begin
      rsp_valid <= res.valid;
    end
    if (slot_free && res.valid) begin
      status     <= res.status;
      read_value <= res.read_value;
      length     <= res.length;
    end
  end

endmodule

// ===== bench/tb_positional_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A directed opening
// drives the boundary positions, every command and the error cases. Random
// phases then grow, churn and shrink the list against a shadow copy kept in
// a queue, with random idle bursts on both sides of the block.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
  import plst_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS    = 1600;
  localparam int QUIET_TAIL     = 200;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    bit                       pause;
  } list_cmd_t;

  typedef struct {
    logic                     status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         length;
  } list_result_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [CMD_W-1:0]         cmd = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic                     status;
  logic signed [DATA_W-1:0] read_value;
  logic [POS_W-1:0]         length;

  list_cmd_t                pending_cmds[$];
  list_result_t             expected_results[$];
  logic signed [DATA_W-1:0] list_contents[$];
  list_cmd_t                driven_cmd;

  int gen_len = 0;
  int items_sent = 0;
  int results_seen = 0;
  int error_count = 0;
  int req_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  int n_insert = 0;
  int n_delete = 0;
  int n_get = 0;
  int n_other = 0;
  int n_rejected = 0;
  int full_rejects = 0;
  int max_length = 0;

  positional_list_engine i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .position   (position),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .read_value (read_value),
    .length     (length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] c, input int p,
                           input logic signed [DATA_W-1:0] v);
    list_cmd_t t;
    t.cmd      = c;
    t.position = p[POS_W-1:0];
    t.value    = v;
    t.pause    = 1'b0;
    pending_cmds.push_back(t);
    case (c)
      CMD_INSERT: if (p >= 1 && p <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
      CMD_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic queue_pause();
    list_cmd_t t;
    t.cmd      = CMD_GET;
    t.position = '0;
    t.value    = '0;
    t.pause    = 1'b1;
    pending_cmds.push_back(t);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_position(input logic [CMD_W-1:0] c);
    int r;
    int top;
    r = $urandom_range(0, 99);
    top = (c == CMD_INSERT) ? gen_len + 1 : gen_len;
    if (r < 85 && top >= 1) begin
      if (r < 10) return 1;
      if (r < 20) return top;
      return $urandom_range(1, top);
    end
    case (r % 5)
      0: return 0;
      1: return 127;
      2: return top + 1;
      3: return $urandom_range(top + 1, 127);
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  task automatic apply_list_cmd(input list_cmd_t t);
    list_result_t r;
    int p;
    p = int'(t.position);
    r.status = 1'b1;
    r.read_value = '0;
    case (t.cmd)
      CMD_INSERT: begin
        n_insert++;
        if (p >= 1 && p <= list_contents.size() + 1 && list_contents.size() < CAPACITY) begin
          list_contents.insert(p - 1, t.value);
          r.status = 1'b0;
        end else if (list_contents.size() == CAPACITY) begin
          full_rejects++;
        end
      end
      CMD_DELETE: begin
        n_delete++;
        if (p >= 1 && p <= list_contents.size()) begin
          list_contents.delete(p - 1);
          r.status = 1'b0;
        end
      end
      CMD_GET: begin
        n_get++;
        if (p >= 1 && p <= list_contents.size()) begin
          r.read_value = list_contents[p - 1];
          r.status = 1'b0;
        end
      end
      default: n_other++;
    endcase
    r.length = POS_W'(list_contents.size());
    if (r.status) n_rejected++;
    if (list_contents.size() > max_length) max_length = list_contents.size();
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    list_cmd_t nxt;
    bit take;
    take = req_valid && !req_stall;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (take) begin
        apply_list_cmd(driven_cmd);
        items_sent <= items_sent + 1;
      end
      if (!req_valid || take) begin
        if (pending_cmds.size() != 0 && pending_cmds[0].pause) begin
          if (!take && items_sent == results_seen) void'(pending_cmds.pop_front());
          req_valid <= 1'b0;
        end else if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          driven_cmd = nxt;
          cmd <= nxt.cmd;
          position <= nxt.position;
          value <= nxt.value;
          req_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 12);
        end else begin
          req_valid <= 1'b0;
        end
      end
      if (pending_cmds.size() <= QUIET_TAIL) quiet <= 1'b1;
    end
  end

  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction, status %0b read_value %0d length %0d",
                   $time, status, read_value, length);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $display("%0t: status mismatch, expected %0b, actual %0b",
                     $time, exp_r.status, status);
            error_count++;
          end
          if (read_value !== exp_r.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, actual %0d",
                     $time, exp_r.read_value, read_value);
            error_count++;
          end
          if (length !== exp_r.length) begin
            $display("%0t: length mismatch, expected %0d, actual %0d",
                     $time, exp_r.length, length);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, expected_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int phase_len;
    int r;
    int ins_pct;
    int del_pct;
    logic [CMD_W-1:0] c;

    queue_cmd(CMD_GET, 1, 0);
    queue_cmd(CMD_DELETE, 1, 0);
    queue_cmd(CMD_INSERT, 0, 32'sh12345678);
    queue_cmd(CMD_INSERT, 2, 32'sh12345678);
    queue_cmd(CMD_INSERT, 1, 32'sh7fffffff);
    queue_cmd(CMD_INSERT, 2, 32'sh80000000);
    queue_cmd(CMD_INSERT, 1, -32'sh1);
    queue_cmd(CMD_INSERT, 2, 32'sh0);
    queue_cmd(CMD_INSERT, 127, 32'sh1);
    for (int i = 1; i <= 5; i++) queue_cmd(CMD_GET, i, 0);
    queue_cmd(CMD_GET, 0, 0);
    queue_cmd(CMD_UNUSED, 1, $urandom);
    queue_cmd(CMD_DELETE, 127, 0);
    queue_cmd(CMD_DELETE, 0, 0);
    queue_cmd(CMD_DELETE, 4, 0);
    queue_cmd(CMD_DELETE, 1, 0);
    queue_cmd(CMD_GET, 1, 0);
    queue_cmd(CMD_GET, 2, 0);
    queue_cmd(CMD_INSERT, 3, 32'sh55555555);
    queue_cmd(CMD_INSERT, 2, 32'shaaaaaaaa);
    queue_pause();

    ph = 0;
    while (pending_cmds.size() < TOTAL_ITEMS) begin
      phase_len = (ph == 0) ? 200 : $urandom_range(80, 200);
      case (ph % 4)
        0: begin ins_pct = 70; del_pct = 80; end
        2: begin ins_pct = 20; del_pct = 75; end
        default: begin ins_pct = 40; del_pct = 70; end
      endcase
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) c = CMD_INSERT;
        else if (r < del_pct) c = CMD_DELETE;
        else if (r < 97) c = CMD_GET;
        else c = CMD_UNUSED;
        queue_cmd(c, pick_position(c), pick_value());
      end
      if (ph % 3 == 1) queue_pause();
      ph++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_cmds.size() != 0 || req_valid || items_sent != results_seen);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    $display("Ran %0d inserts, %0d deletes, %0d gets and %0d unused-code commands; %0d rejected.",
             n_insert, n_delete, n_get, n_other, n_rejected);
    $display("Longest list held %0d entries; %0d inserts were refused on a full list.",
             max_length, full_rejects);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
